// ===== rtl/npcd_pkg.sv =====
`default_nettype none
// ============================================================================
// NTT prime constant derivation package
// Shared types, status codes and controller states.
// ============================================================================
package npcd_pkg;

    localparam int ModulusBitsDefault = 30;
    localparam int MaxModuliDefault   = 8;
    localparam logic [30:0] RingDimReset = 31'd2048;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_DIM  = 3'd1,
        ST_NOPRIME  = 3'd2,
        ST_NOINV    = 3'd3,
        ST_TOO_MANY = 3'd4
    } status_t;

    // Shared-unit operations.
    typedef enum logic [1:0] {
        OP_MODMUL = 2'd0,
        OP_DIVMOD = 2'd1
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SPLIT,
        S_BASE,
        S_EXP_STEP,
        S_EXP_MUL,
        S_EXP_MUL_WAIT,
        S_EXP_SQR,
        S_EXP_SQR_WAIT,
        S_EXP_CHECK,
        S_SQ_LOOP,
        S_SQ_WAIT,
        S_MU_DIV,
        S_MU_WAIT,
        S_INV_INIT,
        S_INV_DIV,
        S_INV_WAIT,
        S_INV_MUL,
        S_INV_MUL_WAIT,
        S_INV_UPD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        op_t  op;
        logic [63:0] a;
        logic [63:0] b;
        logic [31:0] m;
    } unit_cmd_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [31:0] rem;
    } unit_sts_t;

endpackage
`default_nettype wire

// ===== rtl/npcd_unit.sv =====
`default_nettype none
// ============================================================================
// Shared arithmetic unit
// Bit-serial restoring divider giving quotient and remainder of a 64-bit
// dividend by a 32-bit divisor; modular multiply reduces a registered product.
// ============================================================================
module npcd_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire npcd_pkg::unit_cmd_t cmd,
    output npcd_pkg::unit_sts_t    sts
);
    import npcd_pkg::*;

    logic [63:0] num_reg, num_next;
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [63:0] prod;

    assign prod  = cmd.a[31:0] * cmd.b[31:0];
    assign trial = {rem_reg[31:0], num_reg[63]};

    always_comb begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            num_next  = (cmd.op == OP_MODMUL) ? prod : cmd.a;
            den_next  = cmd.m;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[62:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign sts.done = done_reg;
    assign sts.quo  = quo_reg;
    assign sts.rem  = rem_reg[31:0];

endmodule
`default_nettype wire

// ===== rtl/npcd_ctrl.sv =====
`default_nettype none
// ============================================================================
// Controller
// Sequences the prime test, Barrett constant and inverse through the unit.
// ============================================================================
module npcd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic              pre_fail,
    input  wire logic [31:0]       q,
    input  wire logic [30:0]       n_dim,
    input  wire npcd_pkg::unit_sts_t sts,
    output npcd_pkg::unit_cmd_t    cmd,
    output logic                   done,
    output npcd_pkg::status_t      status,
    output logic [62:0]            mu,
    output logic [30:0]            ninv
);
    import npcd_pkg::*;

    localparam logic [31:0] Bases [5] = '{32'd2, 32'd3, 32'd5, 32'd7, 32'd11};

    state_t state_reg, state_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] d_reg, d_next;
    logic [4:0]  s_reg, s_next;
    logic [4:0]  r_reg, r_next;
    logic [31:0] e_reg, e_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] b_reg, b_next;
    logic        fail_reg, fail_next;
    logic [63:0] mu_reg, mu_next;
    logic signed [33:0] t_reg, t_next, nt_reg, nt_next;
    logic [31:0] rr_reg, rr_next, nr_reg, nr_next;
    logic [31:0] qq_reg, qq_next;
    logic [31:0] nmod_reg;
    logic [31:0] qm1;
    logic signed [67:0] tq;
    logic tiny_q;

    assign qm1 = q - 32'd1;
    assign tiny_q = (q == 32'd2) || (q == 32'd3) || (q == 32'd5) || (q == 32'd7)
                    || (q == 32'd11);
    assign tq = $signed({2'b00, qq_reg}) * nt_reg;

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg; d_next = d_reg; s_next = s_reg; r_next = r_reg;
        e_next = e_reg; x_next = x_reg; b_next = b_reg; fail_next = fail_reg;
        mu_next = mu_reg; t_next = t_reg; nt_next = nt_reg; rr_next = rr_reg;
        nr_next = nr_reg; qq_next = qq_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    fail_next = 1'b0;
                    idx_next = '0;
                    if (pre_fail) begin
                        fail_next = 1'b1;
                        state_next = S_DONE;
                    end else if (q < 32'd2 || (!tiny_q && !q[0])) begin
                        fail_next = 1'b1;
                        state_next = S_DONE;
                    end else if (tiny_q) begin
                        state_next = S_MU_DIV;
                    end else begin
                        d_next = qm1;
                        s_next = '0;
                        state_next = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                if (!d_reg[0]) begin
                    d_next = {1'b0, d_reg[31:1]};
                    s_next = s_reg + 5'd1;
                end else begin
                    state_next = S_BASE;
                end
            end
            S_BASE: begin
                if (idx_reg == 3'd5) begin
                    state_next = S_MU_DIV;
                end else if (Bases[idx_reg] >= q) begin
                    idx_next = idx_reg + 3'd1;
                end else begin
                    x_next = 32'd1;
                    b_next = Bases[idx_reg];
                    e_next = d_reg;
                    state_next = S_EXP_STEP;
                end
            end
            S_EXP_STEP: begin
                if (e_reg == 32'd0) state_next = S_EXP_CHECK;
                else if (e_reg[0]) state_next = S_EXP_MUL;
                else state_next = S_EXP_SQR;
            end
            S_EXP_MUL: state_next = S_EXP_MUL_WAIT;
            S_EXP_MUL_WAIT: begin
                if (sts.done) begin
                    x_next = sts.rem;
                    state_next = S_EXP_SQR;
                end
            end
            S_EXP_SQR: state_next = S_EXP_SQR_WAIT;
            S_EXP_SQR_WAIT: begin
                if (sts.done) begin
                    b_next = sts.rem;
                    e_next = {1'b0, e_reg[31:1]};
                    state_next = S_EXP_STEP;
                end
            end
            S_EXP_CHECK: begin
                if (x_reg == 32'd1 || x_reg == qm1) begin
                    idx_next = idx_reg + 3'd1;
                    state_next = S_BASE;
                end else begin
                    r_next = 5'd1;
                    state_next = S_SQ_LOOP;
                end
            end
            S_SQ_LOOP: begin
                if (r_reg >= s_reg) begin
                    fail_next = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT: begin
                if (sts.done) begin
                    x_next = sts.rem;
                    r_next = r_reg + 5'd1;
                    if (sts.rem == qm1) begin
                        idx_next = idx_reg + 3'd1;
                        state_next = S_BASE;
                    end else begin
                        state_next = S_SQ_LOOP;
                    end
                end
            end
            S_MU_DIV: state_next = S_MU_WAIT;
            S_MU_WAIT: begin
                if (sts.done) begin
                    mu_next = (sts.rem == qm1) ? sts.quo + 64'd1 : sts.quo;
                    state_next = S_INV_INIT;
                end
            end
            S_INV_INIT: state_next = S_INV_DIV;
            S_INV_DIV: begin
                if (nr_reg == 32'd0) state_next = S_DONE;
                else state_next = S_INV_WAIT;
            end
            S_INV_WAIT: begin
                if (sts.done) begin
                    qq_next = sts.quo[31:0];
                    state_next = S_INV_MUL;
                end
            end
            S_INV_MUL: state_next = S_INV_UPD;
            S_INV_UPD: begin
                t_next  = nt_reg;
                nt_next = t_reg - tq[33:0];
                rr_next = nr_reg;
                nr_next = rr_reg - qq_reg * nr_reg;
                state_next = S_INV_DIV;
            end
            S_INV_MUL_WAIT: state_next = S_INV_UPD;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_INV_INIT) begin
            t_next  = '0;
            nt_next = 34'sd1;
            rr_next = q;
            nr_next = nmod_reg;
        end
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_EXP_MUL: begin
                cmd.start = 1'b1; cmd.op = OP_MODMUL;
                cmd.a = {32'd0, x_reg}; cmd.b = {32'd0, b_reg}; cmd.m = q;
            end
            S_EXP_SQR: begin
                cmd.start = 1'b1; cmd.op = OP_MODMUL;
                cmd.a = {32'd0, b_reg}; cmd.b = {32'd0, b_reg}; cmd.m = q;
            end
            S_SQ_LOOP: begin
                cmd.start = (r_reg < s_reg); cmd.op = OP_MODMUL;
                cmd.a = {32'd0, x_reg}; cmd.b = {32'd0, x_reg}; cmd.m = q;
            end
            S_MU_DIV: begin
                cmd.start = 1'b1; cmd.op = OP_DIVMOD;
                cmd.a = 64'hFFFF_FFFF_FFFF_FFFF; cmd.m = q;
            end
            S_INV_DIV: begin
                cmd.start = (nr_reg != 32'd0); cmd.op = OP_DIVMOD;
                cmd.a = {32'd0, rr_reg}; cmd.m = nr_reg;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        idx_reg <= idx_next; d_reg <= d_next; s_reg <= s_next; r_reg <= r_next;
        e_reg <= e_next; x_reg <= x_next; b_reg <= b_next; fail_reg <= fail_next;
        mu_reg <= mu_next; t_reg <= t_next; nt_reg <= nt_next; rr_reg <= rr_next;
        nr_reg <= nr_next; qq_reg <= qq_next;
        if (start) nmod_reg <= ({1'b0, n_dim} < q) ? {1'b0, n_dim} : 32'd0;
    end

    logic [33:0] t_fix;
    logic        noinv;
    assign t_fix = t_reg[33] ? t_reg + $signed({2'b00, q}) : t_reg;
    assign noinv = (nmod_reg == 32'd0) || (rr_reg > 32'd1) || (t_fix[30:0] == 31'd0);

    assign done = (state_reg == S_DONE);
    always_comb begin
        status = ST_OK;
        mu = mu_reg[62:0];
        ninv = t_fix[30:0];
        if (fail_reg) begin
            status = ST_NOPRIME; mu = '0; ninv = '0;
        end else if (noinv) begin
            status = ST_NOINV; mu = '0; ninv = '0;
        end
    end

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> state_reg == S_IDLE) else $error("done not followed by idle");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == S_IDLE) else $error("start while busy");
    a_done_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.done |-> !cmd.start) else $error("unit restarted on done");

endmodule
`default_nettype wire

// ===== rtl/ntt_prime_constant_derive_top.sv =====
`default_nettype none
// ============================================================================
// NTT prime constant derivation top level
// Checks one modulus per item and derives its Barrett constant and N inverse.
// ============================================================================
// A bad ring dimension or too many moduli is reported straight from the input stage;
// a modulus out of range or off the congruence is passed to the controller as a
// failed item; otherwise the controller runs a sequence of shared-unit operations.
// Throughput: one item in flight; the next item can be accepted in the cycle after the
// result is taken. Reset: synchronous active-low; the ring dimension returns to
// 2048 and the set position to zero.
module ntt_prime_constant_derive_top #(
    parameter int MODULUS_BITS = npcd_pkg::ModulusBitsDefault,
    parameter int MAX_MODULI   = npcd_pkg::MaxModuliDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_modulus,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [3:0]       m_limb_index,
    output logic [62:0]      m_barrett_const,
    output logic [30:0]      m_n_inverse,
    output logic             m_last_out
);
    import npcd_pkg::*;

    localparam logic [3:0] MaxPos = 4'(MAX_MODULI);

    logic [30:0] ring_reg;
    logic [3:0]  pos_reg;
    logic        busy_reg;
    logic [31:0] q_reg;
    logic        go_reg, pre_reg;
    logic        bad_dim, too_many, range_bad, cong_bad;
    unit_cmd_t   cmd;
    unit_sts_t   sts;
    logic        c_done;
    status_t     c_status;
    logic [62:0] c_mu;
    logic [30:0] c_ninv;
    logic        s_acc;
    logic [31:0] twice_m1;

    assign pready = 1'b1;
    assign prdata = {1'b0, ring_reg};
    assign s_ready = !busy_reg && !m_valid;
    assign s_acc = s_valid && s_ready;
    assign bad_dim = (ring_reg == '0) || ((ring_reg & (ring_reg - 31'd1)) != '0);
    assign too_many = (pos_reg >= MaxPos);
    assign twice_m1 = {ring_reg, 1'b0} - 32'd1;
    assign range_bad = (MODULUS_BITS < 32) && (s_modulus >= (32'd1 << MODULUS_BITS));
    assign cong_bad = (s_modulus & twice_m1) != 32'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg <= RingDimReset;
            pos_reg <= '0;
            busy_reg <= 1'b0;
            m_valid <= 1'b0;
            go_reg <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            if (psel && penable && pwrite && paddr == 2'd0) ring_reg <= pwdata[30:0];
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (s_acc) begin
                q_reg <= s_modulus;
                m_limb_index <= pos_reg;
                m_last_out <= s_last;
                if (s_last) pos_reg <= '0;
                else if (!too_many) pos_reg <= pos_reg + 4'd1;
                if (bad_dim || too_many) begin
                    m_status <= bad_dim ? ST_BAD_DIM : ST_TOO_MANY;
                    m_barrett_const <= '0;
                    m_n_inverse <= '0;
                    m_valid <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    go_reg <= 1'b1;
                    pre_reg <= range_bad || cong_bad;
                end
            end
            if (c_done) begin
                busy_reg <= 1'b0;
                m_valid <= 1'b1;
                m_status <= c_status;
                m_barrett_const <= c_mu;
                m_n_inverse <= c_ninv;
            end
        end
    end

    npcd_ctrl u_ctrl (
        .aclk, .aresetn, .start(go_reg), .pre_fail(pre_reg), .q(q_reg),
        .n_dim(ring_reg), .sts, .cmd, .done(c_done), .status(c_status),
        .mu(c_mu), .ninv(c_ninv)
    );

    npcd_unit u_unit (.aclk, .aresetn, .cmd, .sts);

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready) else $error("accepted while busy");
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        c_done |-> busy_reg) else $error("result without item");
    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MaxPos) else $error("position overflow");

endmodule
`default_nettype wire
